@@ design/ogsf_pkg.sv @@
// ---------------------------------------------------------------------------
// ogsf_pkg: shared definitions for the occupancy grid shape fill unit
// Holds item modes, register indexes, reset values and the command and status
// bundles that pass between the controller and the datapath.
// ---------------------------------------------------------------------------
package ogsf_pkg;

	// Default grid side; the top-level parameter takes it from here.
	localparam int MAX_DIM_DEFAULT = 64;

	// Largest half size or radius that a draw item may use.
	localparam int MAX_HALF_SIZE = 15;

	// Value that a read returns for an occupied cell.
	localparam logic [6:0] OCCUPIED_VALUE = 7'd100;

	// Configuration port geometry and register reset values.
	localparam int CFG_DW = 7;
	localparam int CFG_IW = 2;
	localparam logic [CFG_DW-1:0] MAP_WIDTH_RESET  = 7'd10;
	localparam logic [CFG_DW-1:0] MAP_HEIGHT_RESET = 7'd10;
	localparam logic              BORDER_RESET     = 1'b0;

	// Register indexes on the configuration port.
	localparam logic [CFG_IW-1:0] CFG_MAP_WIDTH     = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_MAP_HEIGHT    = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_BORDER_ENABLE = 2'd2;

	// Item modes.
	typedef enum logic [1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_SQUARE = 2'd1,
		MODE_CIRCLE = 2'd2,
		MODE_READ   = 2'd3
	} mode_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;     // latch the accepted item and restart the walk counters
		logic sweep_en;    // write one cell of the full-array sweep
		logic fill_border; // sweep writes the border ring when enabled
		logic draw_en;     // visit one cell of the shape window
		logic mem_read;    // read the addressed cell
		logic out_load;    // load the result register
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic sweep_last;  // sweep counter is on the last cell
		logic draw_last;   // draw walk is on the last cell of the window
	} dp_status_t;

endpackage

@@ design/ogsf_ctrl.sv @@
// ---------------------------------------------------------------------------
// ogsf_ctrl: controller of the occupancy grid shape fill unit
// Sequences the clearing pass after reset, clear sweeps, shape walks and cell
// reads, and owns the input stall and the result valid.
// ---------------------------------------------------------------------------
module ogsf_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            mode,
	output logic                  out_valid,
	input  logic                  out_stall,
	output ogsf_pkg::ctrl_cmd_t   cmd,
	input  ogsf_pkg::dp_status_t  status
);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_CLEAR,
		S_DRAW,
		S_READ,
		S_RESULT
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	// Items are taken only between operations.
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// Commands follow the current state.
	always_comb begin
		cmd = '0;
		case (state_q)
			S_INIT: begin
				cmd.sweep_en = 1'b1;
			end
			S_IDLE: begin
				cmd.capture = in_valid;
			end
			S_CLEAR: begin
				cmd.sweep_en    = 1'b1;
				cmd.fill_border = 1'b1;
			end
			S_DRAW: begin
				cmd.draw_en = 1'b1;
			end
			S_READ: begin
				cmd.mem_read = 1'b1;
			end
			S_RESULT: begin
				cmd.out_load = !out_valid_q || !out_stall;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State register and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			out_valid_q <= 1'b0;
		end else begin
			// The result valid rises at a result load and falls when the item is taken.
			if ((state_q == S_RESULT) && cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					if (status.sweep_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						case (ogsf_pkg::mode_t'(mode))
							ogsf_pkg::MODE_CLEAR: begin
								state_q <= S_CLEAR;
							end
							ogsf_pkg::MODE_SQUARE, ogsf_pkg::MODE_CIRCLE: begin
								state_q <= S_DRAW;
							end
							ogsf_pkg::MODE_READ: begin
								state_q <= S_READ;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_CLEAR: begin
					if (status.sweep_last) begin
						state_q <= S_IDLE;
					end
				end
				S_DRAW: begin
					if (status.draw_last) begin
						state_q <= S_IDLE;
					end
				end
				S_READ: begin
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (cmd.out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_INIT;
				end
			endcase
		end
	end

endmodule

@@ design/ogsf_datapath.sv @@
// ---------------------------------------------------------------------------
// ogsf_datapath: datapath of the occupancy grid shape fill unit
// Holds the configuration registers, the cell memory, the sweep counter, the
// shape walk with clipping and circle test, and the result register.
// ---------------------------------------------------------------------------
module ogsf_datapath #(
	parameter int MAX_DIM = ogsf_pkg::MAX_DIM_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [ogsf_pkg::CFG_IW-1:0]    cfg_index,
	input  logic [ogsf_pkg::CFG_DW-1:0]    cfg_data,
	input  logic signed [7:0]              center_x,
	input  logic signed [7:0]              center_y,
	input  logic [1:0]                     mode,
	input  logic [3:0]                     half_size,
	input  logic [5:0]                     read_col,
	input  logic [5:0]                     read_row,
	input  ogsf_pkg::ctrl_cmd_t            cmd,
	output ogsf_pkg::dp_status_t           status,
	output logic [6:0]                     cell_value,
	output logic                           outside_map
);

	// Column/row index width, memory address width and depth.
	localparam int CW    = $clog2(MAX_DIM);
	localparam int AW    = 2 * CW;
	localparam int DEPTH = 1 << AW;
	// Width that holds both a size register and MAX_DIM.
	localparam int EW    = ($clog2(MAX_DIM + 1) > 7) ? $clog2(MAX_DIM + 1) : 7;
	// Signed width of a shape cell coordinate.
	localparam int XW    = EW + 2;

	logic [ogsf_pkg::CFG_DW-1:0] width_q;
	logic [ogsf_pkg::CFG_DW-1:0] height_q;
	logic                        border_q;

	logic [EW-1:0] eff_w;
	logic [EW-1:0] eff_h;

	logic [3:0]  s_sat;
	logic [7:0]  s_sq;
	logic [10:0] lim;

	logic signed [7:0] cx_q;
	logic signed [7:0] cy_q;
	logic [3:0]        s_q;
	logic [10:0]       lim_q;
	logic              circle_q;
	logic [5:0]        rcol_q;
	logic [5:0]        rrow_q;
	logic              outside_q;
	logic signed [4:0] x_q;
	logic signed [4:0] y_q;
	logic [AW-1:0]     swp_q;

	logic signed [XW-1:0] dx;
	logic signed [XW-1:0] dy;
	logic                 in_map;
	logic [3:0]           ax;
	logic [3:0]           ay;
	logic [8:0]           r2;
	logic                 in_circle;
	logic signed [4:0]    s_pos;

	logic [CW-1:0] scol;
	logic [CW-1:0] srow;
	logic          sweep_in;
	logic          sweep_ring;
	logic          fill;

	logic          we;
	logic [AW-1:0] waddr;
	logic          wdata;
	logic [AW-1:0] raddr;
	logic          mem_q [DEPTH];
	logic          rdata_q;

	logic [6:0] cell_value_q;
	logic       outside_map_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ogsf_pkg::MAP_WIDTH_RESET;
			height_q <= ogsf_pkg::MAP_HEIGHT_RESET;
			border_q <= ogsf_pkg::BORDER_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				ogsf_pkg::CFG_MAP_WIDTH: begin
					width_q <= cfg_data;
				end
				ogsf_pkg::CFG_MAP_HEIGHT: begin
					height_q <= cfg_data;
				end
				ogsf_pkg::CFG_BORDER_ENABLE: begin
					border_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// Map size in use: a size above MAX_DIM acts as MAX_DIM.
	assign eff_w = (EW'(width_q) > EW'(MAX_DIM)) ? EW'(MAX_DIM) : EW'(width_q);
	assign eff_h = (EW'(height_q) > EW'(MAX_DIM)) ? EW'(MAX_DIM) : EW'(height_q);

	// Saturated half size and the circle limit 4s^2 + s.
	assign s_sat = ({3'b000, half_size} > 7'(ogsf_pkg::MAX_HALF_SIZE)) ?
		4'(ogsf_pkg::MAX_HALF_SIZE) : half_size;
	assign s_sq  = s_sat * s_sat;
	assign lim   = {1'b0, s_sq, 2'b00} + 11'(s_sat);

	// Item capture and shape walk, row by row over the window.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cx_q      <= center_x;
			cy_q      <= center_y;
			s_q       <= s_sat;
			lim_q     <= lim;
			circle_q  <= (ogsf_pkg::mode_t'(mode) == ogsf_pkg::MODE_CIRCLE);
			rcol_q    <= read_col;
			rrow_q    <= read_row;
			outside_q <= (EW'(read_col) >= eff_w) || (EW'(read_row) >= eff_h);
			x_q       <= -$signed({1'b0, s_sat});
			y_q       <= -$signed({1'b0, s_sat});
		end else if (cmd.draw_en) begin
			if (x_q == s_pos) begin
				x_q <= -s_pos;
				y_q <= y_q + 5'sd1;
			end else begin
				x_q <= x_q + 5'sd1;
			end
		end
	end

	// Sweep counter; it starts at zero after reset for the clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swp_q <= '0;
		end else if (cmd.capture) begin
			swp_q <= '0;
		end else if (cmd.sweep_en) begin
			swp_q <= swp_q + AW'(1);
		end
	end

	// Shape cell position, clipping and circle test.
	assign s_pos     = $signed({1'b0, s_q});
	assign dx        = XW'(cx_q) + XW'(x_q);
	assign dy        = XW'(cy_q) + XW'(y_q);
	assign in_map    = !dx[XW-1] && (dx[XW-2:0] < (EW + 1)'(eff_w)) &&
		!dy[XW-1] && (dy[XW-2:0] < (EW + 1)'(eff_h));
	assign ax        = x_q[4] ? 4'(-x_q) : x_q[3:0];
	assign ay        = y_q[4] ? 4'(-y_q) : y_q[3:0];
	assign r2        = 9'(ax * ax) + 9'(ay * ay);
	assign in_circle = ({r2, 2'b00} <= lim_q);

	// Sweep cell value: the border ring when enabled, free elsewhere.
	assign scol       = swp_q[CW-1:0];
	assign srow       = swp_q[AW-1:CW];
	assign sweep_in   = (EW'(scol) < eff_w) && (EW'(srow) < eff_h);
	assign sweep_ring = (scol == '0) || (srow == '0) ||
		(EW'(scol) == eff_w - EW'(1)) || (EW'(srow) == eff_h - EW'(1));
	assign fill       = cmd.fill_border && border_q && sweep_in && sweep_ring;

	assign status.sweep_last = &swp_q;
	assign status.draw_last  = (x_q == s_pos) && (y_q == s_pos);

	// Memory port selection.
	assign we    = cmd.sweep_en || (cmd.draw_en && in_map && (!circle_q || in_circle));
	assign waddr = cmd.sweep_en ? swp_q : {dy[CW-1:0], dx[CW-1:0]};
	assign wdata = cmd.sweep_en ? fill : 1'b1;
	assign raddr = {CW'(rrow_q), CW'(rcol_q)};

	// Cell memory, one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (cmd.mem_read) begin
			rdata_q <= mem_q[raddr];
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			cell_value_q  <= (!outside_q && rdata_q) ? ogsf_pkg::OCCUPIED_VALUE : 7'd0;
			outside_map_q <= outside_q;
		end
	end

	assign cell_value  = cell_value_q;
	assign outside_map = outside_map_q;

endmodule

@@ design/occupancy_grid_shape_fill_unit.sv @@
// ---------------------------------------------------------------------------
// occupancy_grid_shape_fill_unit: one-bit occupancy grid with shape fill
// Clears the grid (optionally marking the border ring), draws clipped squares
// and circles, and reads single cells back as 0 or 100.
//
//   Channel   Signals                                          Direction
//   input     in_valid, in_stall, mode .. read_row             in (stall out)
//   output    out_valid, out_stall, cell_value, outside_map    out (stall in)
//   config    cfg_write, cfg_index, cfg_data                   in, no wait
//
// One item at a time; every item spends its accepting cycle before its work.
// A clear walks every memory cell, one write per cycle; the memory holds the
// side MAX_DIM rounded up to a power of two, squared (4096 cells at 64). A
// square or circle walks its window one cell per cycle. A read passes the
// accepting cycle, the registered memory read and the result load in turn.
// After reset a clearing pass over every memory cell runs before any item.
// A held result stalls only the next read, at its result load.
// ---------------------------------------------------------------------------
module occupancy_grid_shape_fill_unit #(
	parameter int MAX_DIM = ogsf_pkg::MAX_DIM_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [ogsf_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [ogsf_pkg::CFG_DW-1:0]  cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   mode,
	input  logic signed [7:0]            center_x,
	input  logic signed [7:0]            center_y,
	input  logic [3:0]                   half_size,
	input  logic [5:0]                   read_col,
	input  logic [5:0]                   read_row,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [6:0]                   cell_value,
	output logic                         outside_map
);

	ogsf_pkg::ctrl_cmd_t  cmd;
	ogsf_pkg::dp_status_t status;

	// Controller.
	ogsf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	// Datapath.
	ogsf_datapath #(
		.MAX_DIM (MAX_DIM)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.center_x    (center_x),
		.center_y    (center_y),
		.mode        (mode),
		.half_size   (half_size),
		.read_col    (read_col),
		.read_row    (read_row),
		.cmd         (cmd),
		.status      (status),
		.cell_value  (cell_value),
		.outside_map (outside_map)
	);

endmodule

@@ bench/occupancy_grid_shape_fill_unit_test.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// occupancy_grid_shape_fill_unit_test: self-checking bench for the grid unit
// Drives clear, square, circle and read items through the valid/stall input
// channel. It first walks a short table of directed items, then runs random
// phases under several map sizes and border settings. A bench grid model
// predicts each read the table does not give. Results are checked in order,
// field by field, while both channels idle and stall at random.
// ---------------------------------------------------------------------------
module occupancy_grid_shape_fill_unit_test;

	localparam int GRID_DIM    = ogsf_pkg::MAX_DIM_DEFAULT;
	localparam int QUIET_WAIT  = 4200;      // a full clear plus margin
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 2500000;

	// One input item and one read result, as the ports carry them.
	typedef struct packed {
		ogsf_pkg::mode_t   mode;
		logic signed [7:0] center_x;
		logic signed [7:0] center_y;
		logic [3:0]        half_size;
		logic [5:0]        read_col;
		logic [5:0]        read_row;
	} grid_item_t;

	typedef struct packed {
		logic [6:0] cell_value;
		logic       outside_map;
	} read_result_t;

	typedef struct packed {
		grid_item_t   item;
		bit           typed;
		read_result_t want;
	} directed_row_t;

	localparam read_result_t CELL_FREE = '{7'd0, 1'b0};
	localparam read_result_t CELL_OCC  = '{ogsf_pkg::OCCUPIED_VALUE, 1'b0};
	localparam read_result_t OFF_MAP   = '{7'd0, 1'b1};
	localparam read_result_t NO_READ   = '0;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_write = 1'b0;
	logic [ogsf_pkg::CFG_IW-1:0] cfg_index = '0;
	logic [ogsf_pkg::CFG_DW-1:0] cfg_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic [1:0]                  mode = ogsf_pkg::MODE_CLEAR;
	logic signed [7:0]           center_x = '0;
	logic signed [7:0]           center_y = '0;
	logic [3:0]                  half_size = '0;
	logic [5:0]                  read_col = '0;
	logic [5:0]                  read_row = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [6:0]                  cell_value;
	logic                        outside_map;

	// Grid model: its own cells and its own copy of the registers.
	bit                  grid_bits [0:GRID_DIM-1][0:GRID_DIM-1];
	logic [6:0]          model_width = ogsf_pkg::MAP_WIDTH_RESET;
	logic [6:0]          model_height = ogsf_pkg::MAP_HEIGHT_RESET;
	logic                model_border = ogsf_pkg::BORDER_RESET;

	read_result_t        pending_reads [$];
	int                  mismatch_count = 0;
	int                  cycle_count = 0;
	int                  sender_idle_pct = 0;
	int                  receiver_stall_pct = 0;
	bit                  hold_start = 1'b0;
	bit                  hold_used = 1'b0;
	int                  hold_left = 0;

	// Directed items under the reset map of 10 by 10 with no border.
	directed_row_t directed_rows [25] = '{
		'{'{ogsf_pkg::MODE_READ,   8'sd0,   8'sd0,   4'd0,  6'd0,  6'd0},  1'b1, CELL_FREE},
		'{'{ogsf_pkg::MODE_READ,   8'sd0,   8'sd0,   4'd0,  6'd9,  6'd9},  1'b1, CELL_FREE},
		'{'{ogsf_pkg::MODE_READ,   8'sd0,   8'sd0,   4'd0,  6'd10, 6'd0},  1'b1, OFF_MAP},
		'{'{ogsf_pkg::MODE_READ,   8'sd0,   8'sd0,   4'd0,  6'd0,  6'd10}, 1'b1, OFF_MAP},
		'{'{ogsf_pkg::MODE_READ,   8'sd0,   8'sd0,   4'd0,  6'd63, 6'd63}, 1'b1, OFF_MAP},
		'{'{ogsf_pkg::MODE_SQUARE, 8'sd5,   8'sd5,   4'd0,  6'd0,  6'd0},  1'b0, NO_READ},
		'{'{ogsf_pkg::MODE_READ,   8'sd0,   8'sd0,   4'd0,  6'd5,  6'd5},  1'b1, CELL_OCC},
		'{'{ogsf_pkg::MODE_SQUARE, 8'sh80,  8'sh80,  4'd15, 6'd0,  6'd0},  1'b0, NO_READ},
		'{'{ogsf_pkg::MODE_SQUARE, 8'sd127, 8'sd127, 4'd15, 6'd0,  6'd0},  1'b0, NO_READ},
		'{'{ogsf_pkg::MODE_READ,   8'sd0,   8'sd0,   4'd0,  6'd0,  6'd0},  1'b1, CELL_FREE},
		'{'{ogsf_pkg::MODE_CIRCLE, 8'sd9,   8'sd0,   4'd0,  6'd0,  6'd0},  1'b0, NO_READ},
		'{'{ogsf_pkg::MODE_READ,   8'sd0,   8'sd0,   4'd0,  6'd9,  6'd0},  1'b1, CELL_OCC},
		'{'{ogsf_pkg::MODE_CIRCLE, 8'sd2,   8'sd7,   4'd1,  6'd0,  6'd0},  1'b0, NO_READ},
		'{'{ogsf_pkg::MODE_READ,   8'sd0,   8'sd0,   4'd0,  6'd3,  6'd8},  1'b0, NO_READ},
		'{'{ogsf_pkg::MODE_READ,   8'sd0,   8'sd0,   4'd0,  6'd3,  6'd7},  1'b0, NO_READ},
		'{'{ogsf_pkg::MODE_CIRCLE, -8'sd3,  8'sd4,   4'd3,  6'd0,  6'd0},  1'b0, NO_READ},
		'{'{ogsf_pkg::MODE_READ,   8'sd0,   8'sd0,   4'd0,  6'd0,  6'd4},  1'b0, NO_READ},
		'{'{ogsf_pkg::MODE_READ,   8'sd0,   8'sd0,   4'd0,  6'd0,  6'd3},  1'b0, NO_READ},
		'{'{ogsf_pkg::MODE_SQUARE, 8'sd0,   8'sd0,   4'd2,  6'd0,  6'd0},  1'b0, NO_READ},
		'{'{ogsf_pkg::MODE_READ,   8'sd0,   8'sd0,   4'd0,  6'd2,  6'd2},  1'b0, NO_READ},
		'{'{ogsf_pkg::MODE_CIRCLE, 8'sd5,   8'sd5,   4'd15, 6'd0,  6'd0},  1'b0, NO_READ},
		'{'{ogsf_pkg::MODE_READ,   8'sd0,   8'sd0,   4'd0,  6'd9,  6'd9},  1'b0, NO_READ},
		'{'{ogsf_pkg::MODE_CLEAR,  8'sd0,   8'sd0,   4'd0,  6'd0,  6'd0},  1'b0, NO_READ},
		'{'{ogsf_pkg::MODE_READ,   8'sd0,   8'sd0,   4'd0,  6'd5,  6'd5},  1'b1, CELL_FREE},
		'{'{ogsf_pkg::MODE_READ,   8'sd0,   8'sd0,   4'd0,  6'h2A, 6'h15}, 1'b1, OFF_MAP}
	};

	occupancy_grid_shape_fill_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.center_x    (center_x),
		.center_y    (center_y),
		.half_size   (half_size),
		.read_col    (read_col),
		.read_row    (read_row),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cell_value  (cell_value),
		.outside_map (outside_map)
	);

	// Free-running clock, 20 ns period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// A size register above the grid side acts as the full side.
	function automatic int fitted_dim(input logic [6:0] v);
		return (v > GRID_DIM) ? GRID_DIM : int'(v);
	endfunction

	// Applies one item to the grid model and returns the read it causes.
	function automatic void occupancy_apply(input grid_item_t it, output bit gives,
			output read_result_t res);
		int w, h, s, cx, cy, lim, dx, dy;
		w = fitted_dim(model_width);
		h = fitted_dim(model_height);
		gives = 1'b0;
		res = NO_READ;
		case (it.mode)
			ogsf_pkg::MODE_CLEAR: begin
				for (int r = 0; r < GRID_DIM; r++)
					for (int c = 0; c < GRID_DIM; c++)
						grid_bits[r][c] = model_border && r < h && c < w &&
							(r == 0 || c == 0 || r == h - 1 || c == w - 1);
			end
			ogsf_pkg::MODE_SQUARE, ogsf_pkg::MODE_CIRCLE: begin
				s = int'(it.half_size);
				if (s > ogsf_pkg::MAX_HALF_SIZE)
					s = ogsf_pkg::MAX_HALF_SIZE;
				cx = it.center_x;
				cy = it.center_y;
				lim = 4 * s * s + s;
				for (int y = -s; y <= s; y++) begin
					for (int x = -s; x <= s; x++) begin
						dx = cx + x;
						dy = cy + y;
						if (dx >= 0 && dx < w && dy >= 0 && dy < h &&
								(it.mode == ogsf_pkg::MODE_SQUARE ||
								4 * (x * x + y * y) <= lim))
							grid_bits[dy][dx] = 1'b1;
					end
				end
			end
			default: begin
				gives = 1'b1;
				if (it.read_col >= w || it.read_row >= h)
					res = OFF_MAP;
				else
					res = grid_bits[it.read_row][it.read_col] ? CELL_OCC : CELL_FREE;
			end
		endcase
	endfunction

	// Random item, mostly aimed at the map and its edges, sometimes anywhere.
	function automatic grid_item_t random_item();
		grid_item_t it;
		int w, h, pick, v;
		w = fitted_dim(model_width);
		h = fitted_dim(model_height);
		pick = $urandom_range(99);
		if (pick < 4)
			it.mode = ogsf_pkg::MODE_CLEAR;
		else if (pick < 25)
			it.mode = ogsf_pkg::MODE_SQUARE;
		else if (pick < 46)
			it.mode = ogsf_pkg::MODE_CIRCLE;
		else
			it.mode = ogsf_pkg::MODE_READ;
		if ($urandom_range(9) == 0) begin
			it.center_x = 8'($urandom);
			it.center_y = 8'($urandom);
		end else begin
			v = int'($urandom_range(w + 7)) - 4;
			it.center_x = v[7:0];
			v = int'($urandom_range(h + 7)) - 4;
			it.center_y = v[7:0];
		end
		it.half_size = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) :
			4'($urandom_range(4));
		if ($urandom_range(7) == 0) begin
			it.read_col = 6'($urandom_range(63));
			it.read_row = 6'($urandom_range(63));
		end else begin
			it.read_col = 6'($urandom_range(w < 63 ? w : 63));
			it.read_row = 6'($urandom_range(h < 63 ? h : 63));
		end
		return it;
	endfunction

	// Prints one line per mismatch and counts it.
	task automatic report_mismatch(input string what, input int got, input int want);
		$display("error at cycle %0d: %s: got %0d, want %0d", cycle_count, what, got, want);
		mismatch_count++;
	endtask

	// Offers one item until it is accepted; valid stays high for a following item.
	task automatic offer_item(input grid_item_t it, input bit typed,
			input read_result_t typed_res);
		bit gives;
		read_result_t res;
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		mode      <= it.mode;
		center_x  <= it.center_x;
		center_y  <= it.center_y;
		half_size <= it.half_size;
		read_col  <= it.read_col;
		read_row  <= it.read_row;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		occupancy_apply(it, gives, res);
		if (gives)
			pending_reads.insert(pending_reads.size(), typed ? typed_res : res);
	endtask

	// Waits for every read to return, then lets a full clear run out.
	task automatic wait_quiet();
		while (pending_reads.size() != 0)
			@(posedge clk);
		repeat (QUIET_WAIT) @(posedge clk);
	endtask

	// Writes all three registers back to back while the block is idle.
	task automatic set_map(input logic [6:0] w, input logic [6:0] h, input logic b);
		cfg_write <= 1'b1;
		cfg_index <= ogsf_pkg::CFG_MAP_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= ogsf_pkg::CFG_MAP_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		cfg_index <= ogsf_pkg::CFG_BORDER_ENABLE;
		cfg_data  <= {{(ogsf_pkg::CFG_DW-1){1'b0}}, b};
		@(posedge clk);
		cfg_write <= 1'b0;
		model_width  = w;
		model_height = h;
		model_border = b;
	endtask

	// One random phase under a given map and idling mix.
	task automatic run_phase(input logic [6:0] w, input logic [6:0] h, input logic b,
			input int idle_pct, input int stall_pct, input bit clear_first,
			input int count, input bit pressure);
		grid_item_t clear_item;
		wait_quiet();
		set_map(w, h, b);
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		if (pressure)
			hold_start <= 1'b1;
		if (clear_first) begin
			clear_item = random_item();
			clear_item.mode = ogsf_pkg::MODE_CLEAR;
			offer_item(clear_item, 1'b0, NO_READ);
		end
		repeat (count) offer_item(random_item(), 1'b0, NO_READ);
		in_valid <= 1'b0;
	endtask

	// Result side: check each taken result, then pick the next stall.
	always @(posedge clk) begin
		read_result_t want;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (pending_reads.size() == 0) begin
				report_mismatch("result with no read pending", cell_value, 0);
			end else begin
				want = pending_reads.pop_front();
				if (cell_value !== want.cell_value)
					report_mismatch("cell_value", cell_value, want.cell_value);
				if (outside_map !== want.outside_map)
					report_mismatch("outside_map", outside_map, want.outside_map);
			end
		end
		if (hold_start && !hold_used) begin
			hold_used <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
	end

	// Guard against a hung block.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	// Stimulus: reset, directed table, then random phases.
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			offer_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
		in_valid <= 1'b0;

		run_phase(7'd64,  7'd64, 1'b1,  0,  0, 1'b1, 24, 1'b0);
		// Shrink without clearing: drawn cells beyond the new width hide.
		run_phase(7'd1,   7'd64, 1'b1, 58,  0, 1'b0, 14, 1'b0);
		// Regrow: hidden cells show again; the receiver holds off for a while.
		run_phase(7'd64,  7'd64, 1'b0,  0,  0, 1'b0, 22, 1'b1);
		run_phase(7'd127, 7'd2,  1'b1,  0, 58, 1'b1, 14, 1'b0);
		// Empty map: draws write nothing, every read is off the map.
		run_phase(7'd0,   7'd10, 1'b1,  8,  8, 1'b1, 10, 1'b0);
		run_phase(7'd37,  7'd21, 1'b1,  0,  0, 1'b1, 24, 1'b0);

		wait_quiet();
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ filelist.f @@
design/ogsf_pkg.sv
design/ogsf_ctrl.sv
design/ogsf_datapath.sv
design/occupancy_grid_shape_fill_unit.sv
bench/occupancy_grid_shape_fill_unit_test.sv
